// ----- hdl/dsw_pkg.sv -----
package dsw_pkg;

	localparam int DATA_BITS  = 40;
	localparam int TIMER_BITS = 24;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = $clog2(DATA_BITS + 1);
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int WAIT_BITS  = 8;

	localparam logic [CFG_IDX_BITS-1:0] CFG_PRE_RELEASE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_LOW    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PULSE    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_INTERVAL = 3'd4;

	localparam logic [TIMER_BITS-1:0] RST_PRE_RELEASE  = TIMER_BITS'(1000);
	localparam logic [TIMER_BITS-1:0] RST_START_LOW    = TIMER_BITS'(19000);
	localparam logic [WAIT_BITS-1:0]  RST_RELEASE      = WAIT_BITS'(55);
	localparam logic [COUNT_BITS-1:0] RST_MAX_PULSE    = COUNT_BITS'(1000);
	localparam logic [TIMER_BITS-1:0] RST_MIN_INTERVAL = TIMER_BITS'(2000000);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_PRE   = 3'd1,
		PH_START = 3'd2,
		PH_WAIT  = 3'd3,
		PH_RESP  = 3'd4,
		PH_BITS  = 3'd5
	} phase_t;

	typedef struct packed {
		logic start_read;
		logic force_read;
		logic line_level;
	} req_item_t;

	typedef struct packed {
		logic                 drive_low;
		logic                 busy_res;
		logic                 done_res;
		logic                 read_ok;
		logic                 from_cache;
		logic [DATA_BITS-1:0] data_word;
	} res_item_t;

	typedef struct packed {
		logic [TIMER_BITS-1:0] pre_release_ticks;
		logic [TIMER_BITS-1:0] start_low_ticks;
		logic [WAIT_BITS-1:0]  release_ticks;
		logic [COUNT_BITS-1:0] max_pulse_ticks;
		logic [TIMER_BITS-1:0] min_interval_ticks;
	} cfg_regs_t;

	typedef struct packed {
		phase_t                phase;
		logic [TIMER_BITS-1:0] phase_timer;
		logic [COUNT_BITS-1:0] low_count;
		logic [COUNT_BITS-1:0] high_count;
		logic                  measuring_high;
		logic [IDX_BITS-1:0]   bit_index;
		logic [DATA_BITS-1:0]  shift_data;
		logic [DATA_BITS-1:0]  cached_data;
		logic                  cached_ok;
		logic [TIMER_BITS-1:0] since_last_read;
	} rdr_state_t;

endpackage

// ----- hdl/dsw_step.sv -----
module dsw_step (
	input  dsw_pkg::rdr_state_t cur,
	input  dsw_pkg::cfg_regs_t  cfg,
	input  dsw_pkg::req_item_t  req,
	output dsw_pkg::rdr_state_t nxt,
	output dsw_pkg::res_item_t  res
);
	import dsw_pkg::*;

	localparam logic [TIMER_BITS-1:0] TMR_TOP = {TIMER_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CNT_TOP = {COUNT_BITS{1'b1}};

	logic [TIMER_BITS-1:0] tmr_inc;
	logic [TIMER_BITS-1:0] since_inc;
	logic [COUNT_BITS-1:0] low_inc;
	logic [COUNT_BITS-1:0] high_inc;
	logic [TIMER_BITS-1:0] phase_len;
	logic                  tmr_hit;
	logic [IDX_BITS-1:0]   idx_inc;
	logic [DATA_BITS-1:0]  shift_in;
	logic                  early;
	logic                  started;
	logic                  fail;
	logic                  success;
	logic                  cache_hit;

	assign tmr_inc   = (cur.phase_timer == TMR_TOP) ? cur.phase_timer : cur.phase_timer + 1'b1;
	assign since_inc = (cur.since_last_read == TMR_TOP) ? cur.since_last_read
	                                                    : cur.since_last_read + 1'b1;
	assign low_inc   = (cur.low_count == CNT_TOP) ? cur.low_count : cur.low_count + 1'b1;
	assign high_inc  = (cur.high_count == CNT_TOP) ? cur.high_count : cur.high_count + 1'b1;
	assign idx_inc   = cur.bit_index + 1'b1;
	assign shift_in  = {cur.shift_data[DATA_BITS-2:0], (cur.high_count > cur.low_count)};
	assign early     = !req.force_read && (cur.since_last_read < cfg.min_interval_ticks);

	always_comb begin
		case (cur.phase)
			PH_PRE:   phase_len = cfg.pre_release_ticks;
			PH_START: phase_len = cfg.start_low_ticks;
			default:  phase_len = TIMER_BITS'(cfg.release_ticks);
		endcase
	end
	assign tmr_hit = (tmr_inc >= phase_len);

	// next state
	always_comb begin
		nxt       = cur;
		started   = 1'b0;
		fail      = 1'b0;
		success   = 1'b0;
		cache_hit = 1'b0;
		case (cur.phase)
			PH_IDLE: begin
				if (req.start_read) begin
					if (early) begin
						cache_hit = 1'b1;
					end else begin
						started            = 1'b1;
						nxt.phase          = PH_PRE;
						nxt.phase_timer    = '0;
						nxt.shift_data     = '0;
						nxt.bit_index      = '0;
						nxt.low_count      = '0;
						nxt.high_count     = '0;
						nxt.measuring_high = 1'b0;
					end
				end
			end
			PH_PRE, PH_START, PH_WAIT: begin
				nxt.phase_timer = tmr_hit ? '0 : tmr_inc;
				if (tmr_hit) begin
					case (cur.phase)
						PH_PRE:   nxt.phase = PH_START;
						PH_START: nxt.phase = PH_WAIT;
						default: begin
							nxt.phase          = PH_RESP;
							nxt.low_count      = '0;
							nxt.high_count     = '0;
							nxt.measuring_high = 1'b0;
						end
					endcase
				end
			end
			PH_RESP, PH_BITS: begin
				if (!cur.measuring_high) begin
					if (!req.line_level) begin
						nxt.low_count = low_inc;
						fail = (low_inc >= cfg.max_pulse_ticks);
					end else begin
						nxt.measuring_high = 1'b1;
						nxt.high_count     = COUNT_BITS'(1);
						fail = (COUNT_BITS'(1) >= cfg.max_pulse_ticks);
					end
				end else if (req.line_level) begin
					nxt.high_count = high_inc;
					fail = (high_inc >= cfg.max_pulse_ticks);
				end else begin
					if (cur.phase == PH_BITS) begin
						nxt.shift_data = shift_in;
						nxt.bit_index  = idx_inc;
						success = (idx_inc >= IDX_BITS'(DATA_BITS));
					end else begin
						nxt.phase = PH_BITS;
					end
					if (!success) begin
						nxt.measuring_high = 1'b0;
						nxt.low_count      = COUNT_BITS'(1);
						fail = (COUNT_BITS'(1) >= cfg.max_pulse_ticks);
					end
				end
			end
			default: nxt.phase = PH_IDLE;
		endcase

		if (fail) begin
			nxt.phase       = PH_IDLE;
			nxt.cached_ok   = 1'b0;
			nxt.cached_data = '0;
		end else if (success) begin
			nxt.phase       = PH_IDLE;
			nxt.cached_ok   = 1'b1;
			nxt.cached_data = shift_in;
		end

		nxt.since_last_read = started ? '0 : since_inc;
	end

	// result fields
	always_comb begin
		res            = '0;
		res.drive_low  = (nxt.phase == PH_START);
		res.busy_res   = (nxt.phase != PH_IDLE);
		res.done_res   = cache_hit || fail || success;
		res.from_cache = cache_hit;
		if (cache_hit) begin
			res.read_ok   = cur.cached_ok;
			res.data_word = cur.cached_data;
		end else if (success && !fail) begin
			res.read_ok   = 1'b1;
			res.data_word = shift_in;
		end
	end

endmodule

// ----- hdl/dht_single_wire_reader.sv -----
// Channel | Handshake             | Payload
// req     | req_valid / req_ready | req   (start_read, force_read, line_level)
// res     | res_valid / res_ready | res   (drive_low .. data_word)
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle while req_ready is high: each request is one timing tick,
// and its result is registered on acceptance. The reader state and the result
// register advance together, so req_ready drops only while a result waits.
// Reset clears control state, loads register defaults and saturates the
// interval counter so the first read is never early. cfg is always ready.
module dht_single_wire_reader (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  dsw_pkg::req_item_t                  req,
	output logic                                res_valid,
	input  logic                                res_ready,
	output dsw_pkg::res_item_t                  res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dsw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [dsw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import dsw_pkg::*;

	cfg_regs_t  cfg_q;
	rdr_state_t state_q;
	rdr_state_t state_nxt;
	res_item_t  res_nxt;
	res_item_t  res_q;
	logic       res_valid_q;
	logic       req_take;

	// advance whenever the result slot is empty or being drained this cycle
	assign req_ready = !res_valid_q || res_ready;
	assign req_take  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// configuration registers: truncate data to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_release_ticks  <= RST_PRE_RELEASE;
			cfg_q.start_low_ticks    <= RST_START_LOW;
			cfg_q.release_ticks      <= RST_RELEASE;
			cfg_q.max_pulse_ticks    <= RST_MAX_PULSE;
			cfg_q.min_interval_ticks <= RST_MIN_INTERVAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PRE_RELEASE:  cfg_q.pre_release_ticks  <= cfg_data[TIMER_BITS-1:0];
				CFG_START_LOW:    cfg_q.start_low_ticks    <= cfg_data[TIMER_BITS-1:0];
				CFG_RELEASE:      cfg_q.release_ticks      <= cfg_data[WAIT_BITS-1:0];
				CFG_MAX_PULSE:    cfg_q.max_pulse_ticks    <= cfg_data[COUNT_BITS-1:0];
				CFG_MIN_INTERVAL: cfg_q.min_interval_ticks <= cfg_data[TIMER_BITS-1:0];
				default: ;
			endcase
		end
	end

	dsw_step u_step (
		.cur (state_q),
		.cfg (cfg_q),
		.req (req),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// reader state: hold unless a tick is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, since_last_read: '1, default: '0};
		end else if (req_take) begin
			state_q <= state_nxt;
		end
	end

	// result register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			res_q <= res_nxt;
		end
	end

	a_cache_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.from_cache |-> res_q.done_res && !res_q.busy_res)
		else $error("cached answer given while a read is in progress");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.drive_low |-> res_q.busy_res && (state_q.phase == PH_START))
		else $error("line driven low outside the start signal");

	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.read_ok |-> res_q.done_res)
		else $error("read_ok without a result");

	a_cache_upd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res && !res_q.from_cache
		|-> state_q.cached_ok == res_q.read_ok && state_q.cached_data == res_q.data_word)
		else $error("cache not updated with the finished read");

endmodule
